>>> sv/mcsdft_pkg.sv
// Package for the multichannel sliding DFT bin block.
// Holds widths, payload types and the coefficient table; no dependencies.
package mcsdft_pkg;

  localparam int WIN_LEN      = 32;
  localparam int POS_W        = $clog2(WIN_LEN);
  localparam int MAX_CH       = 4;
  localparam int DEF_CHANNELS = 4;
  localparam int SAMPLE_W     = 16;
  localparam int COEF_W       = 16;
  localparam int TERM_W       = SAMPLE_W + COEF_W;
  localparam int DELTA_W      = TERM_W + 1;
  localparam int SUM_W        = 36;
  localparam int MAG_W        = SUM_W + 1;
  localparam int BIN_W        = 5;

  typedef logic        [BIN_W-1:0]    bin_t;
  typedef logic        [POS_W-1:0]    pos_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [TERM_W-1:0]   term_t;
  typedef logic signed [DELTA_W-1:0]  delta_t;
  typedef logic signed [SUM_W-1:0]    sum_t;
  typedef logic        [MAG_W-1:0]    mag_t;

  localparam bin_t BIN_RESET = 5'd4;

  typedef struct packed {
    sample_t sample_ch0;
    sample_t sample_ch1;
    sample_t sample_ch2;
    sample_t sample_ch3;
    logic    clear;
  } in_item_t;

  typedef struct packed {
    sum_t real_ch0;
    sum_t imag_ch0;
    mag_t mag_ch0;
    sum_t real_ch1;
    sum_t imag_ch1;
    mag_t mag_ch1;
    sum_t real_ch2;
    sum_t imag_ch2;
    mag_t mag_ch2;
    sum_t real_ch3;
    sum_t imag_ch3;
    mag_t mag_ch3;
  } out_item_t;

  typedef struct packed {
    logic valid;
    logic clear;
  } stage_ctl_t;

  typedef struct packed {
    delta_t re;
    delta_t im;
  } cdelta_t;

  typedef cdelta_t cdelta_vec_t [MAX_CH];

  // trunc(32767 * cos(j * pi / 16)), j = 0..8
  function automatic coef_t coef_mag(input logic [3:0] j);
    case (j)
      4'd0:    return 16'sd32767;
      4'd1:    return 16'sd32137;
      4'd2:    return 16'sd30272;
      4'd3:    return 16'sd27244;
      4'd4:    return 16'sd23169;
      4'd5:    return 16'sd18204;
      4'd6:    return 16'sd12539;
      4'd7:    return 16'sd6392;
      default: return 16'sd0;
    endcase
  endfunction

  // Real coefficient: A * cos(2*pi*m/WIN_LEN), folded by quadrant
  function automatic coef_t coef_re(input pos_t m);
    logic [3:0] r;
    logic [3:0] rr;
    r  = {1'b0, m[2:0]};
    rr = 4'd8 - r;
    case (m[4:3])
      2'd0:    return coef_mag(r);
      2'd1:    return -coef_mag(rr);
      2'd2:    return -coef_mag(r);
      default: return coef_mag(rr);
    endcase
  endfunction

  // Imaginary coefficient: -A * sin(2*pi*m/WIN_LEN)
  function automatic coef_t coef_im(input pos_t m);
    logic [3:0] r;
    logic [3:0] rr;
    r  = {1'b0, m[2:0]};
    rr = 4'd8 - r;
    case (m[4:3])
      2'd0:    return -coef_mag(rr);
      2'd1:    return -coef_mag(r);
      2'd2:    return coef_mag(rr);
      default: return coef_mag(r);
    endcase
  endfunction

endpackage

>>> sv/mcsdft_in_if.sv
// Input channel interface: valid/ready plus one multichannel sample transaction.
// Depends on mcsdft_pkg.
interface mcsdft_in_if;
  import mcsdft_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/mcsdft_out_if.sv
// Result channel interface: valid/ready plus one bin result transaction.
// Depends on mcsdft_pkg.
interface mcsdft_out_if;
  import mcsdft_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/mcsdft_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module mcsdft_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

>>> sv/mcsdft_window.sv
// Window front end: position counter, coefficient lookup, window RAM read-modify-write,
// products and term differences. Depends on mcsdft_pkg and mcsdft_ram.
module mcsdft_window #(
  parameter int CHANNELS = mcsdft_pkg::DEF_CHANNELS
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  mcsdft_pkg::bin_t         cfg_wr_data,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  mcsdft_pkg::in_item_t     in_data,
  input  logic                     acc_ready,
  output mcsdft_pkg::stage_ctl_t   s3_ctl,
  output mcsdft_pkg::cdelta_vec_t  s3_delta
);
  import mcsdft_pkg::*;

  localparam int CH_W  = 2 * TERM_W;
  localparam int RAM_W = CHANNELS * CH_W;

  bin_t               bin_r;
  pos_t               pos_r, pos_nxt;
  logic [WIN_LEN-1:0] wvalid_r, wvalid_nxt;
  logic               v1_r, v1_nxt, v2_r, v2_nxt, v3_r, v3_nxt;
  logic               accept, move1, move2, move3;

  logic [POS_W+BIN_W-1:0] mprod;
  pos_t                   m_idx;
  sample_t                smp_in [MAX_CH];

  logic    clr1_r, ok1_r;
  pos_t    pos1_r;
  coef_t   cre1_r, cim1_r;
  sample_t smp1_r [MAX_CH];

  term_t prod_re [MAX_CH];
  term_t prod_im [MAX_CH];
  term_t old_re  [MAX_CH];
  term_t old_im  [MAX_CH];

  logic  clr2_r;
  term_t new_re2_r [MAX_CH];
  term_t new_im2_r [MAX_CH];
  term_t old_re2_r [MAX_CH];
  term_t old_im2_r [MAX_CH];

  logic        clr3_r;
  cdelta_vec_t delta3_r;

  logic             wr_en, rd_en;
  logic [RAM_W-1:0] wr_data, rd_data;

  // Flow control: a stage advances when the next one is empty or advancing
  assign move3    = v3_r && acc_ready;
  assign move2    = v2_r && (!v3_r || move3);
  assign move1    = v1_r && (!v2_r || move2);
  assign in_ready = !v1_r || move1;
  assign accept   = in_valid && in_ready;

  assign v1_nxt = accept ? 1'b1 : (move1 ? 1'b0 : v1_r);
  assign v2_nxt = move1  ? 1'b1 : (move2 ? 1'b0 : v2_r);
  assign v3_nxt = move2  ? 1'b1 : (move3 ? 1'b0 : v3_r);

  // Coefficient position (pos * bin) mod WIN_LEN
  assign mprod = {{BIN_W{1'b0}}, pos_r} * {{POS_W{1'b0}}, bin_r};
  assign m_idx = mprod[POS_W-1:0];

  assign smp_in[0] = in_data.sample_ch0;
  assign smp_in[1] = in_data.sample_ch1;
  assign smp_in[2] = in_data.sample_ch2;
  assign smp_in[3] = in_data.sample_ch3;

  always_comb begin
    pos_nxt    = pos_r;
    wvalid_nxt = wvalid_r;
    if (accept) begin
      if (in_data.clear) begin
        pos_nxt    = '0;
        wvalid_nxt = '0;
      end else begin
        wvalid_nxt[pos_r] = 1'b1;
        pos_nxt = (pos_r == POS_W'(WIN_LEN - 1)) ? '0 : pos_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bin_r    <= BIN_RESET;
      pos_r    <= '0;
      wvalid_r <= '0;
      v1_r     <= 1'b0;
      v2_r     <= 1'b0;
      v3_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        bin_r <= cfg_wr_data;
      end
      pos_r    <= pos_nxt;
      wvalid_r <= wvalid_nxt;
      v1_r     <= v1_nxt;
      v2_r     <= v2_nxt;
      v3_r     <= v3_nxt;
    end
  end

  for (genvar ch = 0; ch < MAX_CH; ch++) begin : g_ch
    if (ch < CHANNELS) begin : g_on
      assign prod_re[ch] = TERM_W'(cre1_r) * TERM_W'(smp1_r[ch]);
      assign prod_im[ch] = TERM_W'(cim1_r) * TERM_W'(smp1_r[ch]);
      // Entries not written since the last purge read as zero
      assign old_re[ch]  = ok1_r ? term_t'(rd_data[ch*CH_W +: TERM_W]) : '0;
      assign old_im[ch]  = ok1_r ? term_t'(rd_data[ch*CH_W+TERM_W +: TERM_W]) : '0;
      assign wr_data[ch*CH_W +: TERM_W]        = prod_re[ch];
      assign wr_data[ch*CH_W+TERM_W +: TERM_W] = prod_im[ch];
    end else begin : g_off
      assign prod_re[ch] = '0;
      assign prod_im[ch] = '0;
      assign old_re[ch]  = '0;
      assign old_im[ch]  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      clr1_r <= in_data.clear;
      pos1_r <= pos_r;
      ok1_r  <= wvalid_r[pos_r];
      cre1_r <= coef_re(m_idx);
      cim1_r <= coef_im(m_idx);
      for (int ch = 0; ch < MAX_CH; ch++) begin
        smp1_r[ch] <= smp_in[ch];
      end
    end
    if (move1) begin
      clr2_r <= clr1_r;
      for (int ch = 0; ch < MAX_CH; ch++) begin
        new_re2_r[ch] <= prod_re[ch];
        new_im2_r[ch] <= prod_im[ch];
        old_re2_r[ch] <= old_re[ch];
        old_im2_r[ch] <= old_im[ch];
      end
    end
    if (move2) begin
      clr3_r <= clr2_r;
      for (int ch = 0; ch < MAX_CH; ch++) begin
        delta3_r[ch].re <= DELTA_W'(new_re2_r[ch]) - DELTA_W'(old_re2_r[ch]);
        delta3_r[ch].im <= DELTA_W'(new_im2_r[ch]) - DELTA_W'(old_im2_r[ch]);
      end
    end
  end

  // Read the old term at acceptance; write the new one as stage 1 advances, unless clear
  assign rd_en = accept;
  assign wr_en = move1 && !clr1_r;

  mcsdft_ram #(
    .WIDTH (RAM_W),
    .DEPTH (WIN_LEN)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (pos1_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (pos_r),
    .rd_data (rd_data)
  );

  assign s3_ctl.valid = v3_r;
  assign s3_ctl.clear = clr3_r;
  assign s3_delta     = delta3_r;

  a_no_collision: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && rd_en |-> pos1_r != pos_r)
    else $error("window RAM read and write hit the same entry");

  a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r && !move1 |-> !rd_en)
    else $error("RAM read issued while stage 1 holds its read data");

  a_clear_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.clear |=> pos_r == '0 && wvalid_r == '0)
    else $error("clear transaction did not restart the window");

endmodule

>>> sv/mcsdft_accum.sv
// Running sums per channel and the registered result stage with L1 magnitude.
// Depends on mcsdft_pkg.
module mcsdft_accum (
  input  logic                    clk,
  input  logic                    rst_n,
  input  mcsdft_pkg::stage_ctl_t  s3_ctl,
  input  mcsdft_pkg::cdelta_vec_t s3_delta,
  output logic                    acc_ready,
  output logic                    out_valid,
  input  logic                    out_ready,
  output mcsdft_pkg::out_item_t   out_data
);
  import mcsdft_pkg::*;

  sum_t      sum_re_r [MAX_CH];
  sum_t      sum_im_r [MAX_CH];
  logic      v4_r, out_valid_r;
  logic      move3, move4, move_out;
  out_item_t out_data_r, out_nxt;

  logic [SUM_W-1:0] abs_re [MAX_CH];
  logic [SUM_W-1:0] abs_im [MAX_CH];
  mag_t             mag    [MAX_CH];

  assign move_out  = out_valid_r && out_ready;
  assign move4     = v4_r && (!out_valid_r || move_out);
  assign acc_ready = !v4_r || move4;
  assign move3     = s3_ctl.valid && acc_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r        <= 1'b0;
      out_valid_r <= 1'b0;
      for (int ch = 0; ch < MAX_CH; ch++) begin
        sum_re_r[ch] <= '0;
        sum_im_r[ch] <= '0;
      end
    end else begin
      v4_r        <= move3 ? 1'b1 : (move4 ? 1'b0 : v4_r);
      out_valid_r <= move4 ? 1'b1 : (move_out ? 1'b0 : out_valid_r);
      if (move3) begin
        for (int ch = 0; ch < MAX_CH; ch++) begin
          if (s3_ctl.clear) begin
            sum_re_r[ch] <= '0;
            sum_im_r[ch] <= '0;
          end else begin
            sum_re_r[ch] <= sum_re_r[ch] + SUM_W'(s3_delta[ch].re);
            sum_im_r[ch] <= sum_im_r[ch] + SUM_W'(s3_delta[ch].im);
          end
        end
      end
    end
  end

  for (genvar ch = 0; ch < MAX_CH; ch++) begin : g_mag
    assign abs_re[ch] = sum_re_r[ch][SUM_W-1] ? $unsigned(-sum_re_r[ch])
                                              : $unsigned(sum_re_r[ch]);
    assign abs_im[ch] = sum_im_r[ch][SUM_W-1] ? $unsigned(-sum_im_r[ch])
                                              : $unsigned(sum_im_r[ch]);
    assign mag[ch]    = MAG_W'(abs_re[ch]) + MAG_W'(abs_im[ch]);
  end

  always_comb begin
    out_nxt          = '0;
    out_nxt.real_ch0 = sum_re_r[0];
    out_nxt.imag_ch0 = sum_im_r[0];
    out_nxt.mag_ch0  = mag[0];
    out_nxt.real_ch1 = sum_re_r[1];
    out_nxt.imag_ch1 = sum_im_r[1];
    out_nxt.mag_ch1  = mag[1];
    out_nxt.real_ch2 = sum_re_r[2];
    out_nxt.imag_ch2 = sum_im_r[2];
    out_nxt.mag_ch2  = mag[2];
    out_nxt.real_ch3 = sum_re_r[3];
    out_nxt.imag_ch3 = sum_im_r[3];
    out_nxt.mag_ch3  = mag[3];
  end

  always_ff @(posedge clk) begin
    if (move4) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_sum_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !move3 |=> sum_re_r[0] == $past(sum_re_r[0]) && sum_im_r[0] == $past(sum_im_r[0]))
    else $error("running sum changed without an incoming transaction");

endmodule

>>> sv/multichannel_sliding_dft_bin_top.sv
// Multichannel sliding DFT, single selectable bin.
// Input channel in_if: one transaction carries a 16-bit sample per channel and a
// clear flag. Result channel out_if: per channel the running real and imaginary
// bin sums (36 bits) and the L1 magnitude (37 bits), one result per input.
// Configuration: cfg_wr_en / cfg_wr_data load the 5-bit bin index (reset 4);
// write it only while no transaction is in flight.
// Throughput: one transaction per cycle sustained while out_if.ready is high.
// Each sample does one read-modify-write of its window RAM entry; consecutive samples
// use consecutive entries, so the RAM port pair never stalls the pipeline.
// Pipeline: an accepted transaction passes the RAM read, coefficient multiply,
// term difference, accumulate and magnitude register, then out_if.valid rises.
// Reset: synchronous, active low; clears sums, position, window valid bits and
// loads bin index 4. Window RAM contents are masked by valid bits, no sweep.
// Clear transaction: restarts the window at once and returns an all-zero result.
// Receiver stall: the result register holds; upstream stages keep filling until
// the pipeline is full, then in_if.ready drops.
// Depends on mcsdft_pkg, the channel interfaces, mcsdft_window and mcsdft_accum.
module multichannel_sliding_dft_bin_top #(
  parameter int CHANNELS = mcsdft_pkg::DEF_CHANNELS
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  mcsdft_pkg::bin_t cfg_wr_data,
  mcsdft_in_if.sink        in_if,
  mcsdft_out_if.source     out_if
);
  import mcsdft_pkg::*;

  stage_ctl_t  s3_ctl;
  cdelta_vec_t s3_delta;
  logic        acc_ready;

  mcsdft_window #(
    .CHANNELS (CHANNELS)
  ) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_if.valid),
    .in_ready    (in_if.ready),
    .in_data     (in_if.data),
    .acc_ready   (acc_ready),
    .s3_ctl      (s3_ctl),
    .s3_delta    (s3_delta)
  );

  mcsdft_accum u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .s3_ctl    (s3_ctl),
    .s3_delta  (s3_delta),
    .acc_ready (acc_ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .out_data  (out_if.data)
  );

endmodule
